[rtl/core/vdm_pkg.sv]
// Shared definitions for the virtqueue descriptor manager: request codes,
// request and response beat layouts and default sizes.
// No dependencies.
package vdm_pkg;

  localparam int NUM_DESC_DEF   = 256;
  localparam int NUM_QUEUES_DEF = 4;

  localparam int              LINK_W        = 16;
  localparam logic [15:0]     EMPTY_LINK    = 16'hffff;
  localparam int              CFG_W         = 4;
  localparam logic [3:0]      RING_LOG2_RST = 4'd8;

  typedef enum logic [2:0] {
    REQ_ALLOC  = 3'd0,
    REQ_CHAIN  = 3'd1,
    REQ_FREE   = 3'd2,
    REQ_SUBMIT = 3'd3,
    REQ_INIT   = 3'd4
  } req_kind_t;

  typedef struct packed {
    logic [8:0] chain_count;
    logic [7:0] desc_id;
    logic [1:0] queue;
    logic [2:0] req_type;
  } req_t;

  typedef struct packed {
    logic [7:0]  avail_slot;
    logic [15:0] avail_index;
    logic [8:0]  free_left;
    logic [7:0]  result_index;
    logic        status;
  } rsp_t;

endpackage

[rtl/core/vdm_link_ram.sv]
// Descriptor link table: next link and chained flag of every descriptor of
// every queue, one write or one registered read per cycle. Uses vdm_pkg.
module vdm_link_ram #(
  parameter int ADDR_W = 10
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         addr,
  input  logic [vdm_pkg::LINK_W-1:0] wdata,
  input  logic                      wflag,
  output logic [vdm_pkg::LINK_W-1:0] rdata
);

  logic [vdm_pkg::LINK_W-1:0] link_mem [2**ADDR_W];
  logic                       flag_mem [2**ADDR_W];
  logic [vdm_pkg::LINK_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      link_mem[addr] <= wdata;
      flag_mem[addr] <= wflag;
    end
    if (re) begin
      rdata_r <= link_mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/vdm_avail_ram.sv]
// Available ring store: the chain heads submitted to each queue's ring.
// Written one slot per submit. No dependencies.
module vdm_avail_ram #(
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [7:0]        wdata
);

  logic [7:0] ring_mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      ring_mem[addr] <= wdata;
    end
  end

endmodule

[rtl/core/vdm_ctrl.sv]
// Request sequencer and per-queue state (free head, free count, avail index).
// Drives the link table and avail ring ports. Uses vdm_pkg.
module vdm_ctrl #(
  parameter int NUM_DESC   = vdm_pkg::NUM_DESC_DEF,
  parameter int NUM_QUEUES = vdm_pkg::NUM_QUEUES_DEF,
  localparam int AW = $clog2(NUM_DESC),
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [vdm_pkg::CFG_W-1:0]  ring_log2,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  vdm_pkg::req_t              req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output vdm_pkg::rsp_t              rsp,
  output logic                       link_we,
  output logic                       link_re,
  output logic [QW+AW-1:0]           link_addr,
  output logic [vdm_pkg::LINK_W-1:0] link_wdata,
  output logic                       link_wflag,
  input  logic [vdm_pkg::LINK_W-1:0] link_rdata,
  output logic                       av_we,
  output logic [QW+AW-1:0]           av_addr,
  output logic [7:0]                 av_wdata
);

  localparam int TW   = $clog2(NUM_DESC + 1);
  localparam int CMPW = (TW > 9) ? TW : 9;
  localparam logic [3:0] MAXL = 4'($clog2(NUM_DESC + 1) - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_POPR = 6'b000100,
    S_POPW = 6'b001000,
    S_INIT = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  vdm_pkg::req_t        req_r, req_nxt;
  logic [8:0]           rem_r, rem_nxt;
  logic [AW-1:0]        step_r, step_nxt;
  logic                 have_r, have_nxt;
  logic [AW-1:0]        last_r, last_nxt;
  logic [AW-1:0]        pop_r, pop_nxt;
  logic                 status_r, status_nxt;
  logic [7:0]           res_r, res_nxt;
  logic [7:0]           slot_r, slot_nxt;

  logic [15:0]          head_r  [NUM_QUEUES];
  logic [15:0]          head_nxt[NUM_QUEUES];
  logic [TW-1:0]        total_r  [NUM_QUEUES];
  logic [TW-1:0]        total_nxt[NUM_QUEUES];
  logic [15:0]          avidx_r  [NUM_QUEUES];
  logic [15:0]          avidx_nxt[NUM_QUEUES];
  logic [NUM_QUEUES-1:0] active_r, active_nxt;

  logic [QW-1:0]        qi;
  logic                 bad_q;
  logic [15:0]          head_cur;
  logic [TW-1:0]        total_cur;
  logic [15:0]          avidx_cur;
  logic                 head_ok;
  logic                 is_chain;
  logic [3:0]           l_eff;
  logic [TW-1:0]        ring_sz;
  logic [AW-1:0]        ring_mask;
  logic [AW-1:0]        slot_w;

  assign qi        = QW'(req_r.queue);
  assign bad_q     = 32'(req_r.queue) >= NUM_QUEUES;
  assign head_cur  = head_r[qi];
  assign total_cur = total_r[qi];
  assign avidx_cur = avidx_r[qi];
  // A pop stops on an empty marker or a link that points past the table.
  assign head_ok   = (head_cur != vdm_pkg::EMPTY_LINK) && (head_cur < 16'(NUM_DESC));
  assign is_chain  = req_r.req_type == vdm_pkg::REQ_CHAIN;

  // Ring size is clamped to the largest power of two that fits the table.
  assign l_eff     = (ring_log2 > MAXL) ? MAXL : ring_log2;
  assign ring_sz   = TW'(1) << l_eff;
  assign ring_mask = AW'(ring_sz - TW'(1));
  assign slot_w    = avidx_cur[AW-1:0] & ring_mask;

  assign req_ready = state_r == S_IDLE;
  assign rsp_valid = state_r == S_DONE;

  always_comb begin
    rsp.status       = status_r;
    rsp.result_index = res_r;
    rsp.free_left    = bad_q ? 9'd0 : 9'(total_cur);
    rsp.avail_index  = bad_q ? 16'd0 : avidx_cur;
    rsp.avail_slot   = slot_r;
  end

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    rem_nxt    = rem_r;
    step_nxt   = step_r;
    have_nxt   = have_r;
    last_nxt   = last_r;
    pop_nxt    = pop_r;
    status_nxt = status_r;
    res_nxt    = res_r;
    slot_nxt   = slot_r;
    head_nxt   = head_r;
    total_nxt  = total_r;
    avidx_nxt  = avidx_r;
    active_nxt = active_r;
    link_we    = 1'b0;
    link_re    = 1'b0;
    link_addr  = {qi, pop_r};
    link_wdata = '0;
    link_wflag = 1'b0;
    av_we      = 1'b0;
    av_addr    = {qi, slot_w};
    av_wdata   = req_r.desc_id;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          req_nxt    = req;
          status_nxt = 1'b0;
          res_nxt    = 8'd0;
          slot_nxt   = 8'd0;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        if (bad_q) begin
          status_nxt = 1'b1;
        end else begin
          case (req_r.req_type)
            vdm_pkg::REQ_ALLOC: begin
              if (total_cur == '0) begin
                status_nxt = 1'b1;
              end else begin
                rem_nxt   = 9'd1;
                have_nxt  = 1'b0;
                state_nxt = S_POPR;
              end
            end
            vdm_pkg::REQ_CHAIN: begin
              if (req_r.chain_count == 9'd0 ||
                  CMPW'(req_r.chain_count) > CMPW'(total_cur)) begin
                status_nxt = 1'b1;
              end else begin
                rem_nxt   = req_r.chain_count;
                have_nxt  = 1'b0;
                state_nxt = S_POPR;
              end
            end
            vdm_pkg::REQ_FREE: begin
              if (32'(req_r.desc_id) < NUM_DESC && total_cur < TW'(NUM_DESC)) begin
                link_we       = 1'b1;
                link_addr     = {qi, AW'(req_r.desc_id)};
                link_wdata    = head_cur;
                head_nxt[qi]  = 16'(req_r.desc_id);
                total_nxt[qi] = total_cur + TW'(1);
              end
            end
            vdm_pkg::REQ_SUBMIT: begin
              av_we         = 1'b1;
              slot_nxt      = 8'(slot_w);
              avidx_nxt[qi] = avidx_cur + 16'd1;
            end
            vdm_pkg::REQ_INIT: begin
              avidx_nxt[qi]  = 16'd0;
              active_nxt[qi] = 1'b1;
              step_nxt       = '0;
              state_nxt      = S_INIT;
            end
            default: begin
            end
          endcase
        end
      end
      S_POPR: begin
        if (!head_ok) begin
          status_nxt = 1'b1;
          res_nxt    = 8'd0;
          state_nxt  = S_DONE;
        end else begin
          link_re   = 1'b1;
          link_addr = {qi, head_cur[AW-1:0]};
          pop_nxt   = head_cur[AW-1:0];
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        head_nxt[qi] = link_rdata;
        if (total_cur != '0) begin
          total_nxt[qi] = total_cur - TW'(1);
        end
        // Each descriptor of a chain points back at the one popped before it.
        if (is_chain) begin
          link_we    = 1'b1;
          link_addr  = {qi, pop_r};
          link_wdata = have_r ? 16'(last_r) : 16'd0;
          link_wflag = have_r;
        end
        have_nxt = 1'b1;
        last_nxt = pop_r;
        rem_nxt  = rem_r - 9'd1;
        if (rem_r == 9'd1) begin
          res_nxt   = 8'(pop_r);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_POPR;
        end
      end
      S_INIT: begin
        link_we    = 1'b1;
        link_addr  = {qi, step_r};
        link_wdata = (step_r == '0) ? vdm_pkg::EMPTY_LINK : 16'(step_r - AW'(1));
        step_nxt   = step_r + AW'(1);
        if (step_r == ring_mask) begin
          head_nxt[qi]  = 16'(ring_mask);
          total_nxt[qi] = ring_sz;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      active_r <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i]  <= vdm_pkg::EMPTY_LINK;
        total_r[i] <= '0;
        avidx_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
      head_r   <= head_nxt;
      total_r  <= total_nxt;
      avidx_r  <= avidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    rem_r    <= rem_nxt;
    step_r   <= step_nxt;
    have_r   <= have_nxt;
    last_r   <= last_nxt;
    pop_r    <= pop_nxt;
    status_r <= status_nxt;
    res_r    <= res_nxt;
    slot_r   <= slot_nxt;
  end

endmodule

[rtl/core/virtqueue_descriptor_manager_unit.sv]
// Virtqueue descriptor manager: one request beat in, one response beat out.
// A request passes the exec state, then for alloc and chain a pop read and a pop write per
// descriptor, for init a link write per ring entry, then the done state and output register.
// A new request is taken only once the last one has left the done state; the output
// register frees the sequencer while a response waits. Synchronous reset (rst_n low) empties
// all free lists, clears counts and avail indexes and sets ring_size_log2 to 8.
module virtqueue_descriptor_manager_unit #(
  parameter int NUM_DESC   = vdm_pkg::NUM_DESC_DEF,
  parameter int NUM_QUEUES = vdm_pkg::NUM_QUEUES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [vdm_pkg::CFG_W-1:0] cfg_wdata,   // ring_size_log2
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [23:0]               in_tdata,    // queue, desc_id, chain_count, zero pad
  input  logic [2:0]                in_tuser,    // req_type
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [47:0]               out_tdata,   // result_index, free_left, avail_index,
                                                 // avail_slot, zero pad
  output logic [0:0]                out_tuser    // status
);

  localparam int AW = $clog2(NUM_DESC);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  logic [vdm_pkg::CFG_W-1:0]  ring_log2_r;
  vdm_pkg::req_t              req;
  vdm_pkg::rsp_t              rsp;
  vdm_pkg::rsp_t              out_data_r;
  logic                       out_valid_r, out_valid_nxt;
  logic                       rsp_valid, rsp_ready;
  logic                       link_we, link_re, link_wflag;
  logic [QW+AW-1:0]           link_addr;
  logic [vdm_pkg::LINK_W-1:0] link_wdata, link_rdata;
  logic                       av_we;
  logic [QW+AW-1:0]           av_addr;
  logic [7:0]                 av_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_log2_r <= vdm_pkg::RING_LOG2_RST;
    end else if (cfg_we) begin
      ring_log2_r <= cfg_wdata;
    end
  end

  always_comb begin
    req.req_type    = in_tuser;
    req.queue       = in_tdata[1:0];
    req.desc_id     = in_tdata[9:2];
    req.chain_count = in_tdata[18:10];
  end

  vdm_ctrl #(
    .NUM_DESC   (NUM_DESC),
    .NUM_QUEUES (NUM_QUEUES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .ring_log2  (ring_log2_r),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .link_we    (link_we),
    .link_re    (link_re),
    .link_addr  (link_addr),
    .link_wdata (link_wdata),
    .link_wflag (link_wflag),
    .link_rdata (link_rdata),
    .av_we      (av_we),
    .av_addr    (av_addr),
    .av_wdata   (av_wdata)
  );

  vdm_link_ram #(
    .ADDR_W (QW + AW)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .re    (link_re),
    .addr  (link_addr),
    .wdata (link_wdata),
    .wflag (link_wflag),
    .rdata (link_rdata)
  );

  vdm_avail_ram #(
    .ADDR_W (QW + AW)
  ) u_avail_ram (
    .clk   (clk),
    .we    (av_we),
    .addr  (av_addr),
    .wdata (av_wdata)
  );

  // The output register takes a new response when empty or drained this cycle.
  assign rsp_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rsp_valid && rsp_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      out_data_r <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_data_r.status;
  assign out_tdata  = {7'd0, out_data_r.avail_slot, out_data_r.avail_index,
                       out_data_r.free_left, out_data_r.result_index};

  // The sequencer never takes two requests in back-to-back cycles.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while the previous one is still in work");

  // A stalled response stays offered and unchanged until the output register takes it.
  a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response dropped or changed while the output register was full");

  // A refused request never reports a descriptor.
  a_fail_no_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[7:0] == 8'd0)
    else $error("failed request reports a nonzero descriptor index");

endmodule

[bench/virtqueue_descriptor_manager_unit_tb.sv]
// Self-checking bench for virtqueue_descriptor_manager_unit: stream driver, response monitor,
// and an in-bench model of the per-queue free lists and available indexes.
// Depends on vdm_pkg and the unit under test only.
module virtqueue_descriptor_manager_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DESC_COUNT    = vdm_pkg::NUM_DESC_DEF;
  localparam int QUEUE_COUNT   = vdm_pkg::NUM_QUEUES_DEF;
  localparam int BUSY_PCT      = 77;
  localparam int LIGHT_PCT     = 24;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 5000;
  localparam logic [2:0] REQ_RESERVED_MAX = 3'b111;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [3:0]  cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // queue, desc_id, chain_count, zero pad
  logic [2:0]  in_tuser   = '0;   // req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;         // result_index, free_left, avail_index, avail_slot, zero pad
  logic [0:0]  out_tuser;         // status

  virtqueue_descriptor_manager_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // Model of the block's state.
  logic [15:0] link_mem [QUEUE_COUNT][DESC_COUNT];
  logic [15:0] free_head [QUEUE_COUNT];
  int          free_cnt [QUEUE_COUNT];
  logic [15:0] avail_idx [QUEUE_COUNT];
  logic [3:0]  ring_log2;

  // Descriptors handed out, as {queue, descriptor}; frees and submits draw on them.
  logic [9:0]     held[$];
  vdm_pkg::req_t  pending[$];
  vdm_pkg::rsp_t  due_rsps[$];

  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  bit   hold_armed    = 1'b0;
  bit   hold_taken    = 1'b0;
  int   hold_left     = 0;
  int   quiet_cycles  = 0;
  int   error_count   = 0;
  vdm_pkg::req_t offer;
  vdm_pkg::rsp_t seen;
  vdm_pkg::rsp_t want;

  function automatic int ring_entries();
    int l;
    l = int'(ring_log2);
    while (l > 0 && (1 << l) > DESC_COUNT) l--;
    return 1 << l;
  endfunction

  function automatic void push_free(input int q, input int d);
    link_mem[q][d] = free_head[q];
    free_head[q] = 16'(d);
    free_cnt[q]++;
  endfunction

  // A head that is empty or outside the table stops the pop.
  function automatic bit pop_free(input int q, output int d);
    int h;
    h = int'(free_head[q]);
    d = 0;
    if (h == int'(vdm_pkg::EMPTY_LINK) || h >= DESC_COUNT) return 1'b0;
    free_head[q] = link_mem[q][h];
    if (free_cnt[q] > 0) free_cnt[q]--;
    d = h;
    return 1'b1;
  endfunction

  function automatic vdm_pkg::rsp_t serve_request(input vdm_pkg::req_t r);
    vdm_pkg::rsp_t rsp;
    int   q, d, last, n, i;
    bit   linked;
    rsp = '0;
    q = int'(r.queue);
    last = 0;
    linked = 1'b0;
    case (r.req_type)
      vdm_pkg::REQ_ALLOC: begin
        if (free_cnt[q] == 0) begin
          rsp.status = 1'b1;
        end else if (!pop_free(q, d)) begin
          rsp.status = 1'b1;
        end else begin
          rsp.result_index = 8'(d);
          held.push_back({2'(q), 8'(d)});
        end
      end
      vdm_pkg::REQ_CHAIN: begin
        if (r.chain_count == 9'd0 || free_cnt[q] < int'(r.chain_count)) begin
          rsp.status = 1'b1;
        end else begin
          // Each new descriptor points back at the one popped before it.
          for (n = 0; n < int'(r.chain_count); n++) begin
            if (!pop_free(q, d)) begin
              rsp.status = 1'b1;
              break;
            end
            link_mem[q][d] = linked ? 16'(last) : 16'd0;
            linked = 1'b1;
            last = d;
            held.push_back({2'(q), 8'(d)});
          end
          if (!rsp.status) rsp.result_index = 8'(last);
        end
      end
      vdm_pkg::REQ_FREE: begin
        if (int'(r.desc_id) < DESC_COUNT && free_cnt[q] < DESC_COUNT)
          push_free(q, int'(r.desc_id));
      end
      vdm_pkg::REQ_SUBMIT: begin
        rsp.avail_slot = 8'(avail_idx[q] & 16'(ring_entries() - 1));
        avail_idx[q] = avail_idx[q] + 16'd1;
      end
      vdm_pkg::REQ_INIT: begin
        free_head[q] = vdm_pkg::EMPTY_LINK;
        free_cnt[q] = 0;
        for (i = 0; i < ring_entries(); i++) push_free(q, i);
        avail_idx[q] = '0;
        for (i = held.size() - 1; i >= 0; i--)
          if (held[i][9:8] == 2'(q)) held.delete(i);
      end
      default: ;
    endcase
    rsp.free_left = 9'(free_cnt[q]);
    rsp.avail_index = avail_idx[q];
    return rsp;
  endfunction

  function automatic vdm_pkg::req_t make_req(input logic [2:0] kind, input logic [1:0] q,
                                             input logic [7:0] d, input logic [8:0] cnt);
    vdm_pkg::req_t r;
    r.req_type = kind;
    r.queue = q;
    r.desc_id = d;
    r.chain_count = cnt;
    return r;
  endfunction

  // Mostly alloc/free traffic on descriptors actually held, with some noise mixed in.
  function automatic vdm_pkg::req_t random_req();
    vdm_pkg::req_t r;
    int   pick, i;
    r = make_req(vdm_pkg::REQ_ALLOC, 2'($urandom_range(3)), 8'($urandom_range(255)),
                 9'($urandom_range(1, 8)));
    pick = $urandom_range(99);
    if (pick < 30) begin
      r.req_type = vdm_pkg::REQ_ALLOC;
    end else if (pick < 46) begin
      r.req_type = vdm_pkg::REQ_CHAIN;
      i = $urandom_range(9);
      if (i == 0) r.chain_count = 9'($urandom_range(511));
      else if (i == 1) r.chain_count = 9'(free_cnt[r.queue] + $urandom_range(1));
    end else if (pick < 76) begin
      r.req_type = vdm_pkg::REQ_FREE;
      if (held.size() > 0 && $urandom_range(9) != 0) begin
        i = $urandom_range(held.size() - 1);
        {r.queue, r.desc_id} = held[i];
        held.delete(i);
      end
    end else if (pick < 88) begin
      r.req_type = vdm_pkg::REQ_SUBMIT;
      if (held.size() > 0 && $urandom_range(1) == 1)
        {r.queue, r.desc_id} = held[$urandom_range(held.size() - 1)];
    end else if (pick < 96) begin
      r.req_type = vdm_pkg::REQ_INIT;
    end else begin
      r.req_type = 3'($urandom_range(int'(vdm_pkg::REQ_INIT) + 1, int'(REQ_RESERVED_MAX)));
    end
    return r;
  endfunction

  // Request driver; the model steps on every accepted beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        due_rsps.push_back(serve_request(
          vdm_pkg::req_t'({in_tdata[18:2], in_tdata[1:0], in_tuser})));
      if (!in_tvalid || in_tready) begin
        if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offer = pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {5'b0, offer.chain_count, offer.desc_id, offer.queue};
          in_tuser <= offer.req_type;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and ready generator, including the one long back-pressure stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen.status = out_tuser[0];
        seen.result_index = out_tdata[7:0];
        seen.free_left = out_tdata[16:8];
        seen.avail_index = out_tdata[32:17];
        seen.avail_slot = out_tdata[40:33];
        if (due_rsps.size() == 0) begin
          $display("%0t: response beat with nothing expected: st=%0d idx=%0d free=%0d",
                   $time, seen.status, seen.result_index, seen.free_left);
          error_count++;
        end else begin
          want = due_rsps.pop_front();
          if (seen !== want) begin
            $display({"%0t: expected st=%0d idx=%0d free=%0d avail=%0d slot=%0d, ",
                      "got st=%0d idx=%0d free=%0d avail=%0d slot=%0d"},
                     $time, want.status, want.result_index, want.free_left,
                     want.avail_index, want.avail_slot, seen.status, seen.result_index,
                     seen.free_left, seen.avail_index, seen.avail_slot);
            error_count++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (hold_armed && !hold_taken) begin
        hold_left <= LONG_HOLD;
        hold_taken <= 1'b1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic drain();
    @(negedge clk);
    while (pending.size() != 0 || in_tvalid || due_rsps.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_ring_log2(input logic [3:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ring_log2 = v;
  endtask

  task automatic run_phase(input logic [3:0] log2, input int send_pct, input int recv_pct,
                           input int n_items, input bit squeeze);
    int k;
    write_ring_log2(log2);
    @(negedge clk);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    if (squeeze) hold_armed = 1'b1;
    for (k = 0; k < n_items; k++) begin
      while (pending.size() != 0) @(negedge clk);
      pending.push_back(random_req());
      @(negedge clk);
    end
    drain();
  endtask

  initial begin
    for (int q = 0; q < QUEUE_COUNT; q++) begin
      free_head[q] = vdm_pkg::EMPTY_LINK;
      free_cnt[q] = 0;
      avail_idx[q] = '0;
    end
    ring_log2 = vdm_pkg::RING_LOG2_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Initializing every queue at full size first writes every link entry once.
    for (int q = 0; q < QUEUE_COUNT; q++)
      pending.push_back(make_req(vdm_pkg::REQ_INIT, 2'(q), 8'd0, 9'd0));
    pending.push_back(make_req(vdm_pkg::REQ_ALLOC, 2'd0, 8'd0, 9'd0));
    pending.push_back(make_req(vdm_pkg::REQ_CHAIN, 2'd1, 8'd0, 9'd256));
    pending.push_back(make_req(vdm_pkg::REQ_ALLOC, 2'd1, 8'd0, 9'd0));   // list now empty
    pending.push_back(make_req(vdm_pkg::REQ_CHAIN, 2'd2, 8'd0, 9'd0));   // zero-length chain
    pending.push_back(make_req(vdm_pkg::REQ_CHAIN, 2'd0, 8'd0, 9'h1ff)); // more than are free
    pending.push_back(make_req(vdm_pkg::REQ_FREE, 2'd1, 8'hff, 9'd0));
    pending.push_back(make_req(vdm_pkg::REQ_FREE, 2'd2, 8'd7, 9'd0));    // queue already full
    pending.push_back(make_req(vdm_pkg::REQ_SUBMIT, 2'd2, 8'haa, 9'd0));
    pending.push_back(make_req(vdm_pkg::REQ_SUBMIT, 2'd2, 8'h55, 9'd0));
    pending.push_back(make_req(REQ_RESERVED_MAX, 2'd3, 8'hff, 9'h1ff));
    drain();

    // Two-entry ring: repeated frees of one descriptor leave a count that outlives the list,
    // so a chain breaks partway and a later alloc finds an empty head.
    write_ring_log2(4'd1);
    pending.push_back(make_req(vdm_pkg::REQ_INIT, 2'd3, 8'd0, 9'd0));
    pending.push_back(make_req(vdm_pkg::REQ_FREE, 2'd3, 8'd1, 9'd0));
    pending.push_back(make_req(vdm_pkg::REQ_FREE, 2'd3, 8'd1, 9'd0));
    pending.push_back(make_req(vdm_pkg::REQ_CHAIN, 2'd3, 8'd0, 9'd1));
    pending.push_back(make_req(vdm_pkg::REQ_CHAIN, 2'd3, 8'd0, 9'd3));
    pending.push_back(make_req(vdm_pkg::REQ_ALLOC, 2'd3, 8'd0, 9'd0));
    drain();

    run_phase(4'd3, 0, 0, 120, 1'b0);
    run_phase(4'd0, BUSY_PCT, 0, 80, 1'b0);
    run_phase(4'd15, 0, BUSY_PCT, 60, 1'b1);
    run_phase(4'd2, LIGHT_PCT, LIGHT_PCT, 150, 1'b0);
    run_phase(4'd4, 0, BUSY_PCT, 120, 1'b0);
    run_phase(4'd8, 0, 0, 60, 1'b0);
    run_phase(4'd5, BUSY_PCT, 0, 120, 1'b0);
    run_phase(4'd10, LIGHT_PCT, LIGHT_PCT, 40, 1'b0);
    run_phase(4'd1, 0, 0, 80, 1'b0);

    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/vdm_pkg.sv
rtl/core/vdm_link_ram.sv
rtl/core/vdm_avail_ram.sv
rtl/core/vdm_ctrl.sv
rtl/core/virtqueue_descriptor_manager_unit.sv
bench/virtqueue_descriptor_manager_unit_tb.sv
